// ----- hdl/lph_pkg.sv -----
// Shared constants, request codes and hash helpers for the linear probing hash table.
// No dependencies; compile this file first.
`default_nettype none

package lph_pkg;

	// The slot count must be a power of two so that the home slot is a mask of the hash.
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 64;
	localparam int VAL_W    = 32;
	localparam int REQ_W    = 2;

	// Initial lookup3 state: 0xdeadbeef plus the key length of 8 bytes, seed 0.
	localparam logic [31:0] HASH_INIT = 32'hdeadbef7;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_LOOKUP = 2'd2
	} req_type_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} hash_mid_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int k);
		return (x << k) | (x >> (32 - k));
	endfunction

	// First half of the lookup3 final mix, including loading the key words.
	function automatic hash_mid_t hash_front(input logic [KEY_W-1:0] k);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		hash_mid_t   r;
		a = HASH_INIT + k[31:0];
		b = HASH_INIT + k[63:32];
		c = HASH_INIT;
		c = (c ^ b) - rotl32(b, 14);
		a = (a ^ c) - rotl32(c, 11);
		b = (b ^ a) - rotl32(a, 25);
		c = (c ^ b) - rotl32(b, 16);
		r.a = a;
		r.b = b;
		r.c = c;
		return r;
	endfunction

	// Second half of the final mix; returns the hash word c.
	function automatic logic [31:0] hash_back(input hash_mid_t m);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		a = m.a;
		b = m.b;
		c = m.c;
		a = (a ^ c) - rotl32(c, 4);
		b = (b ^ a) - rotl32(a, 14);
		c = (c ^ b) - rotl32(b, 24);
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/lph_if.sv -----
// Valid/ready channel interfaces for requests and results of the hash table.
// Depends on lph_pkg for field widths.
`default_nettype none

interface lph_req_if import lph_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [KEY_W-1:0] key;
	logic [VAL_W-1:0] value;

	modport source (output valid, output req_type, output key, output value, input ready);
	modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface lph_rsp_if import lph_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             hit;
	logic [VAL_W-1:0] value_out;
	logic             table_full;

	modport source (output valid, output hit, output value_out, output table_full, input ready);
	modport sink   (input valid, input hit, input value_out, input table_full, output ready);
endinterface

`default_nettype wire

// ----- hdl/linear_probe_hash_table_top.sv -----
// Flow: a request taken in ST_IDLE is mixed by lookup3 in ST_HASH1 and ST_HASH2, then moves
// between ST_PROBE and ST_CMP once per occupied slot compared (at most CAPACITY) and ends in
// ST_RESP; an unknown request code goes from ST_HASH2 straight to ST_RESP.
// No new request is taken before ST_RESP has passed its word on; a finished word waits in the output register.
// Reset clears every slot's used flag and the occupancy count at once; no clearing pass.
// Depends on lph_pkg and the channel interfaces in lph_if.sv.
`default_nettype none

module linear_probe_hash_table_top import lph_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	lph_req_if.sink   req,
	lph_rsp_if.source rsp
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_HASH1 = 6'b000010,
		ST_HASH2 = 6'b000100,
		ST_PROBE = 6'b001000,
		ST_CMP   = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	state_t             state_q;
	logic [REQ_W-1:0]   req_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;
	hash_mid_t          mid_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   probes_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CAPACITY-1:0] used_q;

	logic               res_hit_q;
	logic [VAL_W-1:0]   res_val_q;
	logic               res_full_q;

	logic               out_valid_q;
	logic               out_hit_q;
	logic [VAL_W-1:0]   out_val_q;
	logic               out_full_q;

	// Slot memory: key and value of each slot; the used flags live in flip-flops.
	logic [KEY_W+VAL_W-1:0] mem [CAPACITY];
	logic [KEY_W+VAL_W-1:0] rd_s1;
	logic                   mem_we;
	logic [KEY_W-1:0]       rd_key;
	logic [VAL_W-1:0]       rd_val;
	logic [IDX_W-1:0]       idx_next;
	logic                   out_free;
	logic [31:0]            hash_c;

	assign req.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = out_valid_q;
	assign rsp.hit       = out_hit_q;
	assign rsp.value_out = out_val_q;
	assign rsp.table_full = out_full_q;

	assign rd_key   = rd_s1[KEY_W+VAL_W-1:VAL_W];
	assign rd_val   = rd_s1[VAL_W-1:0];
	assign idx_next = (idx_q == IDX_W'(CAPACITY - 1)) ? '0 : idx_q + IDX_W'(1);
	assign out_free = !out_valid_q || rsp.ready;
	assign hash_c   = hash_back(mid_q);

	// An insert writes key and value both when it fills an empty slot and when it updates.
	always_comb begin
		mem_we = 1'b0;
		if (req_q == REQ_INSERT) begin
			if (state_q == ST_PROBE && probes_q != CNT_W'(CAPACITY) && !used_q[idx_q]) begin
				mem_we = 1'b1;
			end else if (state_q == ST_CMP && rd_key == key_q) begin
				mem_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_q] <= {key_q, val_q};
		end
		rd_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			req_q <= req.req_type;
			key_q <= req.key;
			val_q <= req.value;
		end
		if (state_q == ST_HASH1) begin
			mid_q <= hash_front(key_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			probes_q    <= '0;
			cnt_q       <= '0;
			used_q      <= '0;
			res_hit_q   <= 1'b0;
			res_val_q   <= '0;
			res_full_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
			out_val_q   <= '0;
			out_full_q  <= 1'b0;
		end else begin
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
				out_hit_q   <= res_hit_q;
				out_val_q   <= res_val_q;
				out_full_q  <= res_full_q;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_HASH1;
					end
				end
				ST_HASH1: begin
					state_q <= ST_HASH2;
				end
				ST_HASH2: begin
					idx_q      <= hash_c[IDX_W-1:0];
					probes_q   <= '0;
					res_hit_q  <= 1'b0;
					res_val_q  <= '0;
					res_full_q <= 1'b0;
					if (req_q == REQ_INSERT || req_q == REQ_REMOVE || req_q == REQ_LOOKUP) begin
						state_q <= ST_PROBE;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_PROBE: begin
					if (probes_q == CNT_W'(CAPACITY)) begin
						// Every slot was visited without a match or an empty slot.
						res_full_q <= (req_q == REQ_INSERT);
						state_q    <= ST_RESP;
					end else if (!used_q[idx_q]) begin
						if (req_q == REQ_INSERT) begin
							used_q[idx_q] <= 1'b1;
							cnt_q         <= cnt_q + CNT_W'(1);
						end
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (rd_key == key_q) begin
						case (req_q)
							REQ_REMOVE: begin
								res_hit_q     <= 1'b1;
								res_val_q     <= rd_val;
								used_q[idx_q] <= 1'b0;
								cnt_q         <= cnt_q - CNT_W'(1);
							end
							REQ_LOOKUP: begin
								res_hit_q <= 1'b1;
								res_val_q <= rd_val;
							end
							default: begin
							end
						endcase
						state_q <= ST_RESP;
					end else begin
						idx_q    <= idx_next;
						probes_q <= probes_q + CNT_W'(1);
						state_q  <= ST_PROBE;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// The occupancy count always agrees with the used flags.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CNT_W'($countones(used_q)))
		else $error("occupancy count differs from used flags");

	// A memory read is only compared for a slot that holds an entry.
	a_cmp_used: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> used_q[idx_q])
		else $error("compare on an empty slot");

	// The probe never runs past the table size.
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		probes_q <= CNT_W'(CAPACITY))
		else $error("probe count beyond capacity");

	// A full report only comes from a table whose slots are all used.
	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && res_full_q) |-> (cnt_q == CNT_W'(CAPACITY)))
		else $error("table full reported with free slots");

	// A result word never reports both a hit and a full table.
	a_hit_xor_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_hit_q && out_full_q))
		else $error("hit and table full set together");
`endif

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for linear_probe_hash_table_top: directed and random insert, remove,
// lookup and unknown-code words, each predicted by a model of the slot array and compared
// field by field. Depends on lph_pkg and the channel interfaces in lph_if.sv.
`timescale 1ns / 1ps

module testbench;
	import lph_pkg::*;

	localparam int CLK_PERIOD  = 20;
	localparam int KEY_POOL    = 24;
	localparam int LONG_HOLD   = 200;
	localparam int DRAIN_WAIT  = 80;
	localparam int QUIET_LIMIT = 4000;

	// The block answers this undefined code with an all-zero word and no state change.
	localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] value_out;
		logic             table_full;
	} table_response_t;

	logic clk = 1'b0;
	logic arst_n;

	lph_req_if req_ch ();
	lph_rsp_if rsp_ch ();

	linear_probe_hash_table_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predicted contents of the slot array.
	logic [KEY_W-1:0] tbl_key [CAPACITY];
	logic [VAL_W-1:0] tbl_val [CAPACITY];
	bit               tbl_used [CAPACITY];
	int               tbl_occupied;

	table_response_t expected_responses[$];

	int src_idle_pct;
	int sink_idle_pct;
	int hold_pending;
	int hold_left;
	int quiet_cycles;
	int requests_sent;
	int responses_checked;
	int hits_seen;
	int full_seen;
	int mismatches;

	function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// lookup3 final mix of the two key halves; the low bits pick the home slot.
	function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] k);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		a = HASH_INIT + k[31:0];
		b = HASH_INIT + k[63:32];
		c = HASH_INIT;
		c = (c ^ b) - rot_left(b, 14);
		a = (a ^ c) - rot_left(c, 11);
		b = (b ^ a) - rot_left(a, 25);
		c = (c ^ b) - rot_left(b, 16);
		a = (a ^ c) - rot_left(c, 4);
		b = (b ^ a) - rot_left(a, 14);
		c = (c ^ b) - rot_left(b, 24);
		return c[IDX_W-1:0];
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [KEY_W-1:0] key_with_home(input int slot);
		logic [KEY_W-1:0] k;
		k = rand_key();
		while (home_slot(k) != slot[IDX_W-1:0])
			k++;
		return k;
	endfunction

	function automatic bit find_entry(input logic [KEY_W-1:0] k, output int pos);
		int idx;
		idx = int'(home_slot(k));
		pos = 0;
		for (int probe = 0; probe < CAPACITY; probe++) begin
			if (!tbl_used[idx])
				return 1'b0;
			if (tbl_key[idx] == k) begin
				pos = idx;
				return 1'b1;
			end
			idx = (idx + 1) % CAPACITY;
		end
		return 1'b0;
	endfunction

	function automatic table_response_t predict_table_response(input logic [REQ_W-1:0] op,
			input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
		table_response_t res;
		int              pos;
		bit              placed;
		res = '0;
		placed = 1'b0;
		pos = int'(home_slot(k));
		case (op)
			REQ_INSERT: begin
				for (int probe = 0; probe < CAPACITY && !placed; probe++) begin
					if (!tbl_used[pos]) begin
						tbl_used[pos] = 1'b1;
						tbl_key[pos] = k;
						tbl_val[pos] = v;
						tbl_occupied++;
						placed = 1'b1;
					end else if (tbl_key[pos] == k) begin
						tbl_val[pos] = v;
						placed = 1'b1;
					end else begin
						pos = (pos + 1) % CAPACITY;
					end
				end
				res.table_full = !placed;
			end
			REQ_REMOVE: begin
				if (find_entry(k, pos)) begin
					res.hit = 1'b1;
					res.value_out = tbl_val[pos];
					tbl_used[pos] = 1'b0;
					tbl_key[pos] = '0;
					tbl_val[pos] = '0;
					tbl_occupied--;
				end
			end
			REQ_LOOKUP: begin
				if (find_entry(k, pos)) begin
					res.hit = 1'b1;
					res.value_out = tbl_val[pos];
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(input logic [REQ_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= op;
		req_ch.key      <= k;
		req_ch.value    <= v;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		expected_responses.push_back(predict_table_response(op, k, v));
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic test_basic_ops();
		send_word(REQ_INSERT, '0, '1);
		send_word(REQ_INSERT, '1, '0);
		send_word(REQ_LOOKUP, '0, $urandom);
		send_word(REQ_INSERT, '0, 32'h5a5a_a5a5);
		send_word(REQ_LOOKUP, '0, '1);
		send_word(REQ_REMOVE, '1, $urandom);
		send_word(REQ_LOOKUP, '1, $urandom);
		send_word(REQ_UNKNOWN, '0, '1);
	endtask

	// Two keys share the last home slot, so the second wraps; removing the first
	// hides the second, and a re-insert leaves a stale copy further along.
	task automatic test_probe_stop();
		logic [KEY_W-1:0] ka;
		logic [KEY_W-1:0] kb;
		ka = key_with_home(CAPACITY - 1);
		do
			kb = key_with_home(CAPACITY - 1);
		while (kb == ka);
		send_word(REQ_INSERT, ka, $urandom);
		send_word(REQ_INSERT, kb, $urandom);
		send_word(REQ_REMOVE, ka, $urandom);
		send_word(REQ_LOOKUP, kb, $urandom);
		send_word(REQ_INSERT, kb, $urandom);
		send_word(REQ_LOOKUP, kb, $urandom);
		send_word(REQ_REMOVE, kb, $urandom);
		send_word(REQ_LOOKUP, kb, $urandom);
	endtask

	task automatic test_full_table();
		logic [KEY_W-1:0] present;
		logic [KEY_W-1:0] absent;
		while (tbl_occupied < CAPACITY)
			send_word(REQ_INSERT, rand_key(), $urandom);
		present = tbl_key[$urandom_range(CAPACITY - 1)];
		absent = rand_key();
		send_word(REQ_INSERT, absent, $urandom);
		send_word(REQ_INSERT, present, $urandom);
		send_word(REQ_LOOKUP, absent, $urandom);
		send_word(REQ_REMOVE, absent, $urandom);
		send_word(REQ_LOOKUP, present, $urandom);
	endtask

	// Eleven pool keys, the even-indexed ones but the first, pile onto four home slots to build long probe chains.
	task automatic run_random_traffic(input int count);
		logic [KEY_W-1:0] pool [KEY_POOL];
		logic [KEY_W-1:0] k;
		logic [REQ_W-1:0] op;
		int               r;
		for (int i = 0; i < KEY_POOL; i++)
			pool[i] = (i % 2 == 1) ? rand_key() : key_with_home($urandom_range(3));
		pool[0] = '0;
		pool[1] = '1;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 40)
				op = REQ_INSERT;
			else if (r < 65)
				op = REQ_REMOVE;
			else if (r < 95)
				op = REQ_LOOKUP;
			else
				op = REQ_UNKNOWN;
			k = ($urandom_range(9) == 0) ? rand_key() : pool[$urandom_range(KEY_POOL - 1)];
			send_word(op, k, $urandom);
		end
	endtask

	// The result side stops taking words long enough for the request side to back up.
	task automatic test_output_stall();
		hold_pending = LONG_HOLD;
		run_random_traffic(30);
	endtask

	always @(negedge clk) begin
		if (hold_pending > 0) begin
			hold_left = hold_pending;
			hold_pending = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin : check_responses
		table_response_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_responses.size() == 0) begin
				$display("%0t: unexpected word, expected none, got hit=%0b value_out=%h full=%0b",
					$time, rsp_ch.hit, rsp_ch.value_out, rsp_ch.table_full);
				mismatches++;
			end else begin
				want = expected_responses.pop_front();
				responses_checked++;
				if (want.hit)
					hits_seen++;
				if (want.table_full)
					full_seen++;
				if (rsp_ch.hit !== want.hit) begin
					$display("%0t: hit mismatch, expected %0b, got %0b",
						$time, want.hit, rsp_ch.hit);
					mismatches++;
				end
				if (rsp_ch.value_out !== want.value_out) begin
					$display("%0t: value_out mismatch, expected %h, got %h",
						$time, want.value_out, rsp_ch.value_out);
					mismatches++;
				end
				if (rsp_ch.table_full !== want.table_full) begin
					$display("%0t: table_full mismatch, expected %0b, got %0b",
						$time, want.table_full, rsp_ch.table_full);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d responses outstanding",
				$time, QUIET_LIMIT, expected_responses.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_INSERT;
		req_ch.key = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			tbl_key[i] = '0;
			tbl_val[i] = '0;
			tbl_used[i] = 1'b0;
		end
		tbl_occupied = 0;
		hold_pending = 0;
		hold_left = 0;
		quiet_cycles = 0;
		requests_sent = 0;
		responses_checked = 0;
		hits_seen = 0;
		full_seen = 0;
		mismatches = 0;
		src_idle_pct = 22;
		sink_idle_pct = 87;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_ops();
		test_probe_stop();
		test_full_table();
		run_random_traffic(230);
		src_idle_pct = 87;
		sink_idle_pct = 22;
		run_random_traffic(250);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_output_stall();
		run_random_traffic(230);
		req_ch.valid <= 1'b0;

		while (expected_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d requests through directed, full-table, output-stall and random traffic",
			requests_sent);
		$display("under three idle patterns: %0d responses checked, %0d hits, %0d full inserts.",
			responses_checked, hits_seen, full_seen);
		if (mismatches == 0 && expected_responses.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/lph_pkg.sv
hdl/lph_if.sv
hdl/linear_probe_hash_table_top.sv
dv/testbench.sv
